### hw/rtl/sfra_pkg.sv
package sfra_pkg;

   localparam int DEPTH      = 128;
   localparam int DATA_WIDTH = 32;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Smallest group size whose square covers the store, so that the read
   // gather is two balanced levels of OR.
   function automatic int group_size(input int depth);
      int result;
      result = 0;
      for (int g = 1; g <= depth; g++) begin
         if (result == 0 && g * g >= depth) begin
            result = g;
         end
      end
      return result;
   endfunction

   localparam int GROUP  = group_size(DEPTH);
   localparam int NGROUP = (DEPTH + GROUP - 1) / GROUP;

   localparam logic [1:0] CMD_ENQ   = 2'd0;
   localparam logic [1:0] CMD_DEQ   = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_WRITE = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] value;
      logic [6:0]         position;
   } req_type;

   typedef struct packed {
      logic signed [31:0] data;
      logic [1:0]         status;
      logic [7:0]         item_count;
      logic               is_empty;
      logic               is_full;
   } rsp_type;

   typedef struct packed {
      logic                  enq;
      logic                  deq;
      logic                  wr;
      logic [IDX_W-1:0]      idx;
      logic [CNT_W-1:0]      occ;
      logic [DATA_WIDTH-1:0] word;
   } cell_ctrl_type;

endpackage

### hw/rtl/shift_fifo_with_random_access.sv
// Shift-register FIFO with random access. The queue front always sits in
// slot 0; every slot is its own cell, and a dequeue moves all queued words
// down one cell at once. Each request returns exactly one response
// carrying the word, a status and the occupancy after the request. One
// request is handled at a time: a request is taken in S_IDLE, the cells
// update in S_EXEC, and the response register is loaded in S_SUM, so a
// new request is taken only once the last response has been loaded.
// S_SUM exists for the two-level OR gather, whose group level is
// registered, that picks the addressed slot out of the row of cells. A
// request may be taken while the previous response still waits; the
// block holds before loading the response register until it is free.
// Reset clears every slot and the occupancy.
module shift_fifo_with_random_access
   import sfra_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SUM  = 2'd2;

   logic [1:0]            state_ff, state_in;
   req_type               req_ff, req_in;
   logic [CNT_W-1:0]      occ_ff, occ_in;
   logic [1:0]            st_status_ff, st_status_in;
   logic [DATA_WIDTH-1:0] st_data_ff, st_data_in;
   logic                  st_tree_ff, st_tree_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   cell_ctrl_type         ctrl;
   logic [DATA_WIDTH-1:0] slot_word [DEPTH];
   logic [DATA_WIDTH-1:0] read_tap [DEPTH];
   logic [DATA_WIDTH-1:0] merged;

   logic exec, full, empty, pos_ok, req_xfer, rsp_xfer, rsp_load;

   assign exec     = (state_ff == S_EXEC);
   assign full     = (occ_ff >= CNT_W'(DEPTH));
   assign empty    = (occ_ff == '0);
   assign pos_ok   = (32'(req_ff.position) < DEPTH);
   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid_ff && rsp_ready;
   assign rsp_load = (state_ff == S_SUM) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      ctrl.enq  = exec && req_ff.cmd == CMD_ENQ && !full;
      ctrl.deq  = exec && req_ff.cmd == CMD_DEQ && !empty;
      ctrl.wr   = exec && req_ff.cmd == CMD_WRITE && pos_ok;
      ctrl.idx  = IDX_W'(req_ff.position);
      ctrl.occ  = occ_ff;
      ctrl.word = DATA_WIDTH'($unsigned(req_ff.value));
   end

   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         logic [DATA_WIDTH-1:0] upper;
         if (i == DEPTH - 1) begin : g_last
            assign upper = '0;
         end else begin : g_mid
            assign upper = slot_word[i + 1];
         end
         sfra_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cell_index (IDX_W'(i)),
            .ctrl       (ctrl),
            .upper_word (upper),
            .word       (slot_word[i]),
            .read_word  (read_tap[i])
         );
      end
   endgenerate

   sfra_gather u_gather (
      .clock   (clock),
      .capture (exec),
      .taps    (read_tap),
      .merged  (merged)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      occ_in       = occ_ff;
      st_status_in = st_status_ff;
      st_data_in   = st_data_ff;
      st_tree_in   = st_tree_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               req_in   = req_item;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            st_status_in = ST_OK;
            if (req_ff.cmd == CMD_ENQ && full) begin
               st_status_in = ST_FULL;
            end else if ((req_ff.cmd == CMD_DEQ || req_ff.cmd == CMD_READ) && empty) begin
               st_status_in = ST_EMPTY;
            end
            st_data_in = ctrl.deq ? slot_word[0] : '0;
            st_tree_in = req_ff.cmd == CMD_READ && !empty && pos_ok;
            if (ctrl.enq) begin
               occ_in = occ_ff + CNT_W'(1);
            end else if (ctrl.deq) begin
               occ_in = occ_ff - CNT_W'(1);
            end
            state_in = S_SUM;
         end
         S_SUM: begin
            if (rsp_load) begin
               rsp_in.data       = 32'(st_tree_ff ? merged : st_data_ff);
               rsp_in.status     = st_status_ff;
               rsp_in.item_count = 8'(occ_ff);
               rsp_in.is_empty   = empty;
               rsp_in.is_full    = full;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      st_status_ff <= st_status_in;
      st_data_ff   <= st_data_in;
      st_tree_ff   <= st_tree_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(DEPTH))
      else $error("occupancy exceeds the depth");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == S_EXEC)
      else $error("accepted request did not start execution");

   a_deq_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.deq |=> occ_ff == $past(occ_ff) - CNT_W'(1))
      else $error("dequeue did not lower the occupancy by one");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ST_FULL |-> rsp_ff.is_full)
      else $error("full rejection reported without the full flag");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> $stable(rsp_ff))
      else $error("pending response changed before its transfer");
`endif

endmodule

### hw/rtl/sfra_cell.sv
module sfra_cell
   import sfra_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [IDX_W-1:0]      cell_index,
   input  cell_ctrl_type         ctrl,
   input  logic [DATA_WIDTH-1:0] upper_word,
   output logic [DATA_WIDTH-1:0] word,
   output logic [DATA_WIDTH-1:0] read_word
);

   logic [DATA_WIDTH-1:0] word_ff;
   logic [DATA_WIDTH-1:0] word_in;
   logic [CNT_W-1:0]      my_pos;
   logic [CNT_W-1:0]      my_next;

   assign my_pos  = CNT_W'(cell_index);
   assign my_next = my_pos + CNT_W'(1);

   always_comb begin
      word_in = word_ff;
      if (ctrl.enq && my_pos == ctrl.occ) begin
         word_in = ctrl.word;
      end else if (ctrl.deq) begin
         // Queued cells take their upper neighbor; the old tail slot is cleared.
         if (my_next < ctrl.occ) begin
            word_in = upper_word;
         end else if (my_next == ctrl.occ) begin
            word_in = '0;
         end
      end else if (ctrl.wr && cell_index == ctrl.idx) begin
         word_in = ctrl.word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
      end else begin
         word_ff <= word_in;
      end
   end

   assign word      = word_ff;
   assign read_word = (cell_index == ctrl.idx) ? word_ff : '0;

endmodule

### hw/rtl/sfra_gather.sv
module sfra_gather
   import sfra_pkg::*;
(
   input  logic                  clock,
   input  logic                  capture,
   input  logic [DATA_WIDTH-1:0] taps [DEPTH],
   output logic [DATA_WIDTH-1:0] merged
);

   logic [DATA_WIDTH-1:0] grp_ff [NGROUP];
   logic [DATA_WIDTH-1:0] grp_in [NGROUP];

   // Only the addressed cell drives a nonzero tap, so OR selects it.
   always_comb begin
      for (int g = 0; g < NGROUP; g++) begin
         grp_in[g] = '0;
         for (int m = 0; m < GROUP; m++) begin
            if (g * GROUP + m < DEPTH) begin
               grp_in[g] = grp_in[g] | taps[g * GROUP + m];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         grp_ff <= grp_in;
      end
   end

   always_comb begin
      merged = '0;
      for (int g = 0; g < NGROUP; g++) begin
         merged = merged | grp_ff[g];
      end
   end

endmodule

### tb/sv/tb_shift_fifo_with_random_access.sv
`timescale 1ns / 1ps

module tb_shift_fifo_with_random_access;
   import sfra_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 10;

   typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;

   // Queue model kept in step with accepted requests.
   logic [DATA_WIDTH-1:0] queue_words [DEPTH];
   int                    queue_occ;
   rsp_type               expected_rsps [$];

   int               mismatches   = 0;
   int               stall_cycles = 0;
   int               send_idle_pct;
   int               rsp_idle_pct;
   traffic_mode_type traffic_mode = MODE_FILL;
   int               mode_tail    = 6;

   shift_fifo_with_random_access u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always #5 clock = ~clock;

   function automatic rsp_type apply_queue_op(input req_type r);
      rsp_type o;
      int      i;
      o = '0;
      case (r.cmd)
         CMD_ENQ: begin
            if (queue_occ >= DEPTH) begin
               o.status = ST_FULL;
            end else begin
               queue_words[queue_occ] = r.value;
               queue_occ++;
            end
         end
         CMD_DEQ: begin
            if (queue_occ == 0) begin
               o.status = ST_EMPTY;
            end else begin
               o.data = queue_words[0];
               for (i = 0; i + 1 < queue_occ; i++) begin
                  queue_words[i] = queue_words[i + 1];
               end
               queue_words[queue_occ - 1] = '0;
               queue_occ--;
            end
         end
         CMD_READ: begin
            if (queue_occ == 0) begin
               o.status = ST_EMPTY;
            end else if (int'(r.position) < DEPTH) begin
               o.data = queue_words[r.position];
            end
         end
         default: begin
            // Writes ignore the occupancy, so a slot beyond the tail may be set.
            if (int'(r.position) < DEPTH) begin
               queue_words[r.position] = r.value;
            end
         end
      endcase
      o.item_count = queue_occ[7:0];
      o.is_empty   = (queue_occ == 0);
      o.is_full    = (queue_occ >= DEPTH);
      return o;
   endfunction

   task automatic check_response(input rsp_type exp_rsp, input rsp_type act_rsp);
      if (act_rsp.data !== exp_rsp.data) begin
         $display("%0t: data expected %0d, got %0d", $time, exp_rsp.data, act_rsp.data);
         mismatches++;
      end
      if (act_rsp.status !== exp_rsp.status) begin
         $display("%0t: status expected %0d, got %0d", $time, exp_rsp.status,
                  act_rsp.status);
         mismatches++;
      end
      if (act_rsp.item_count !== exp_rsp.item_count) begin
         $display("%0t: item_count expected %0d, got %0d", $time, exp_rsp.item_count,
                  act_rsp.item_count);
         mismatches++;
      end
      if (act_rsp.is_empty !== exp_rsp.is_empty) begin
         $display("%0t: is_empty expected %0b, got %0b", $time, exp_rsp.is_empty,
                  act_rsp.is_empty);
         mismatches++;
      end
      if (act_rsp.is_full !== exp_rsp.is_full) begin
         $display("%0t: is_full expected %0b, got %0b", $time, exp_rsp.is_full,
                  act_rsp.is_full);
         mismatches++;
      end
   endtask

   // Requests are predicted before responses are checked, so the order of
   // the two transfers within one edge never matters.
   always @(posedge clock) begin
      if (reset) begin
         queue_occ = 0;
         for (int i = 0; i < DEPTH; i++) begin
            queue_words[i] = '0;
         end
      end else begin
         stall_cycles++;
         if (req_valid && req_ready) begin
            expected_rsps.push_back(apply_queue_op(req_item));
            stall_cycles = 0;
         end
         if (rsp_valid && rsp_ready) begin
            stall_cycles = 0;
            if (expected_rsps.size() == 0) begin
               $display("%0t: response with none expected, got data %0d status %0d",
                        $time, rsp_item.data, rsp_item.status);
               mismatches++;
            end else begin
               check_response(expected_rsps.pop_front(), rsp_item);
            end
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_op(input logic [1:0] cmd, input logic [31:0] value,
                          input logic [6:0] position);
      req_type r;
      r.cmd      = cmd;
      r.value    = value;
      r.position = position;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= r;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic test_empty_queue();
      send_op(CMD_READ, 32'h0, 7'd0);
      send_op(CMD_DEQ, 32'hFFFF_FFFF, 7'd0);
      send_op(CMD_WRITE, 32'h1234_5678, 7'd127);
      send_op(CMD_READ, 32'h0, 7'd127);
   endtask

   task automatic test_value_extremes();
      send_op(CMD_ENQ, 32'h8000_0000, 7'd0);
      send_op(CMD_ENQ, 32'h7FFF_FFFF, 7'd127);
      send_op(CMD_ENQ, 32'hFFFF_FFFF, 7'd0);
      send_op(CMD_ENQ, 32'h0000_0000, 7'd0);
      send_op(CMD_READ, 32'h0, 7'd0);
      send_op(CMD_READ, 32'h0, 7'd3);
      send_op(CMD_READ, 32'h0, 7'd127);
      repeat (4) send_op(CMD_DEQ, 32'h0, 7'd0);
   endtask

   task automatic test_write_beyond_tail();
      send_op(CMD_ENQ, 32'hAAAA_AAAA, 7'd0);
      send_op(CMD_ENQ, 32'h5555_5555, 7'd0);
      send_op(CMD_WRITE, 32'hC0DE_0004, 7'd4);
      send_op(CMD_READ, 32'h0, 7'd4);
      send_op(CMD_DEQ, 32'h0, 7'd0);
      send_op(CMD_READ, 32'h0, 7'd4);
      send_op(CMD_READ, 32'h0, 7'd1);
      send_op(CMD_WRITE, 32'h0BAD_F00D, 7'd0);
      send_op(CMD_DEQ, 32'h0, 7'd0);
      send_op(CMD_DEQ, 32'h0, 7'd0);
   endtask

   // Long runs of enqueues and dequeues carry the queue between empty and
   // full; the mixed stretch in between is uniform noise.
   task automatic test_random_traffic(input int items, input int send_pct, input int rsp_pct);
      int enq_pct;
      int deq_pct;
      int pick;
      logic [1:0] cmd;
      logic [6:0] position;
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
      repeat (items) begin
         if (traffic_mode == MODE_FILL && queue_occ >= DEPTH) mode_tail--;
         if (traffic_mode == MODE_DRAIN && queue_occ == 0) mode_tail--;
         if (traffic_mode == MODE_MIXED) mode_tail--;
         if (mode_tail <= 0) begin
            case (traffic_mode)
               MODE_FILL: begin
                  traffic_mode = MODE_DRAIN;
                  mode_tail    = 6;
               end
               MODE_DRAIN: begin
                  traffic_mode = MODE_MIXED;
                  mode_tail    = 40;
               end
               default: begin
                  traffic_mode = MODE_FILL;
                  mode_tail    = 6;
               end
            endcase
         end
         case (traffic_mode)
            MODE_FILL: begin
               enq_pct = 85;
               deq_pct = 5;
            end
            MODE_DRAIN: begin
               enq_pct = 5;
               deq_pct = 85;
            end
            default: begin
               enq_pct = 25;
               deq_pct = 25;
            end
         endcase
         pick = $urandom_range(0, 99);
         if (pick < enq_pct) cmd = CMD_ENQ;
         else if (pick < enq_pct + deq_pct) cmd = CMD_DEQ;
         else if (pick[0]) cmd = CMD_READ;
         else cmd = CMD_WRITE;
         if (queue_occ > 0 && $urandom_range(0, 1) == 1) begin
            position = 7'($urandom_range(0, queue_occ - 1));
         end else begin
            position = 7'($urandom_range(0, DEPTH - 1));
         end
         send_op(cmd, $urandom, position);
      end
   endtask

   initial begin
      send_idle_pct = 24;
      rsp_idle_pct  = 66;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_empty_queue();
      test_value_extremes();
      test_write_beyond_tail();
      test_random_traffic(150, 24, 66);
      test_random_traffic(150, 66, 24);
      test_random_traffic(150, 0, 0);
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
